@@ src/activity_indexed_max_heap_macros.svh @@
// Assertion macros for the activity heap.
// Included by the top level; they use the aclk and aresetn signals of the includer.
`ifndef ACTIVITY_INDEXED_MAX_HEAP_MACROS_SVH
`define ACTIVITY_INDEXED_MAX_HEAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIMH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AIMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/aimh_pkg.sv @@
// Shared types and constants for the activity heap.
// No dependencies; used by every module of the block.
package aimh_pkg;

    localparam int MAX_VARS = 1024;
    localparam int VAR_W    = $clog2(MAX_VARS);
    localparam int CNT_W    = VAR_W + 1;
    localparam int ACT_W    = 32;
    localparam int FAC_W    = 17;
    localparam int SHF_W    = 5;
    localparam int REQ_W    = 3;
    localparam int ADDR_W   = 4;
    localparam int PROD_W   = ACT_W + FAC_W;
    localparam int QDEPTH   = 2;

    localparam logic [ACT_W-1:0]  ACT_ONE  = ACT_W'(65536);
    localparam logic [PROD_W:0]   ROUND    = (PROD_W+1)'(32768);

    // Request codes as they arrive on the input channel.
    localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUMP   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DECAY  = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_NUM_VARS = 2'd0;
    localparam logic [1:0] REG_FACTOR   = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;
    localparam logic [1:0] REG_SHIFT    = 2'd3;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_INSERT = 3'd1,
        OP_BUMP   = 3'd2,
        OP_POP    = 3'd3,
        OP_DECAY  = 3'd4,
        OP_NOP    = 3'd5
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAR_W-1:0] var_idx;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] num_vars;
        logic [FAC_W-1:0] factor;
        logic [ACT_W-1:0] limit;
        logic [SHF_W-1:0] shift;
    } cfg_t;

    typedef struct packed {
        logic sweeping;
        logic busy;
    } stat_t;

endpackage

@@ src/aimh_front.sv @@
// Front end of the activity heap: accepts input beats, classifies requests.
// Holds a two-entry command queue toward the back end; uses aimh_pkg.
module aimh_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [aimh_pkg::REQ_W-1:0] s_req_type,
    input  logic [aimh_pkg::VAR_W-1:0] s_var_index,
    output aimh_pkg::cmd_t             cmd_o,
    output logic                       cmd_valid_o,
    input  logic                       cmd_ready_i
);
    import aimh_pkg::*;

    cmd_t       q_mem [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.var_idx = s_var_index;
        case (s_req_type)
            REQ_INIT:   cmd_in.op = OP_INIT;
            REQ_INSERT: cmd_in.op = OP_INSERT;
            REQ_BUMP:   cmd_in.op = OP_BUMP;
            REQ_POP:    cmd_in.op = OP_POP;
            REQ_DECAY:  cmd_in.op = OP_DECAY;
            default:    cmd_in.op = OP_NOP;
        endcase
    end

    assign s_ready     = (fill_reg != 2'(QDEPTH));
    assign cmd_valid_o = (fill_reg != 2'd0);
    assign cmd_o       = q_mem[rd_ptr_reg];
    assign push        = s_valid && s_ready;
    assign pop         = cmd_valid_o && cmd_ready_i;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ src/aimh_back.sv @@
// Back end of the activity heap: heap memories, sift sequencer, sweeps, result register.
// Takes commands from aimh_front; uses aimh_pkg.
module aimh_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aimh_pkg::cfg_t             cfg_i,
    input  aimh_pkg::cmd_t             cmd_i,
    input  logic                       cmd_valid_i,
    output logic                       cmd_ready_o,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [aimh_pkg::VAR_W-1:0] m_popped_var,
    output logic                       m_popped_valid,
    output logic [aimh_pkg::CNT_W-1:0] m_heap_size,
    output aimh_pkg::stat_t            stat_o
);
    import aimh_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_INIT    = 16'h0002,
        S_IN_RD   = 16'h0004,
        S_BUMP_RD = 16'h0008,
        S_RESCALE = 16'h0010,
        S_POP_TOP = 16'h0020,
        S_POP_KEY = 16'h0040,
        S_UP_CHK  = 16'h0080,
        S_UP_SLOT = 16'h0100,
        S_UP_ACT  = 16'h0200,
        S_DN_CHK  = 16'h0400,
        S_DN_SLOT = 16'h0800,
        S_DN_ACT  = 16'h1000,
        S_DEC_MUL = 16'h2000,
        S_DEC_SAT = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    // Memories.
    logic [VAR_W-1:0] hs_mem  [MAX_VARS];
    logic [VAR_W-1:0] sv_mem  [MAX_VARS];
    logic             ih_mem  [MAX_VARS];
    logic [ACT_W-1:0] act_mem [MAX_VARS];

    logic             hs_we, sv_we, ih_we, act_we;
    logic [VAR_W-1:0] hs_wa, hs_wd, sv_wa, sv_wd, ih_wa, act_wa;
    logic             ih_wd;
    logic [ACT_W-1:0] act_wd;
    logic [VAR_W-1:0] hs_ra_a, hs_ra_b, act_ra_a, act_ra_b, sv_ra, ih_ra;
    logic [VAR_W-1:0] hs_a_reg, hs_b_reg, sv_rd_reg;
    logic             ih_rd_reg;
    logic [ACT_W-1:0] act_a_reg, act_b_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  init_n_reg, init_n_next;
    logic              silent_reg, silent_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ACT_W-1:0]  inc_reg, inc_next;
    logic [VAR_W-1:0]  var_reg, var_next;
    logic [VAR_W-1:0]  pos_reg, pos_next;
    logic [ACT_W-1:0]  key_reg, key_next;
    logic              inh_reg, inh_next;
    logic [VAR_W-1:0]  uv_reg, uv_next;
    logic [VAR_W-1:0]  kv0_reg, kv0_next, kv1_reg, kv1_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [VAR_W-1:0]  popped_reg, popped_next;
    logic              pval_reg, pval_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAR_W-1:0]  out_var_reg, out_var_next;
    logic              out_pval_reg, out_pval_next;
    logic [CNT_W-1:0]  out_size_reg, out_size_next;

    logic              place_en;
    logic [VAR_W-1:0]  place_pos, place_var;
    logic [CNT_W-1:0]  kid;
    logic [CNT_W:0]    kid1;
    logic              kid1_in, take_right;
    logic [VAR_W-1:0]  up_pos;
    logic [ACT_W:0]    bump_sum;
    logic [ACT_W-1:0]  bump_act, kid_act;
    logic [PROD_W:0]   dec_sum;

    assign kid        = {pos_reg, 1'b1};
    assign kid1       = {1'b0, pos_reg, 1'b0} + (CNT_W+1)'(2);
    assign kid1_in    = kid1 < {1'b0, count_reg};
    assign take_right = kid1_in && (act_b_reg > act_a_reg);
    assign kid_act    = take_right ? act_b_reg : act_a_reg;
    assign up_pos     = (pos_reg - VAR_W'(1)) >> 1;
    assign bump_sum   = {1'b0, act_a_reg} + {1'b0, inc_reg};
    assign bump_act   = bump_sum[ACT_W] ? {ACT_W{1'b1}} : bump_sum[ACT_W-1:0];
    assign dec_sum    = {1'b0, prod_reg} + ROUND;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        init_n_next    = init_n_reg;
        silent_next    = silent_reg;
        count_next     = count_reg;
        inc_next       = inc_reg;
        var_next       = var_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        inh_next       = inh_reg;
        uv_next        = uv_reg;
        kv0_next       = kv0_reg;
        kv1_next       = kv1_reg;
        prod_next      = prod_reg;
        popped_next    = popped_reg;
        pval_next      = pval_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_var_next   = out_var_reg;
        out_pval_next  = out_pval_reg;
        out_size_next  = out_size_reg;

        place_en  = 1'b0;
        place_pos = pos_reg;
        place_var = var_reg;
        hs_ra_a   = '0;
        hs_ra_b   = '0;
        act_ra_a  = '0;
        act_ra_b  = '0;
        sv_ra     = cmd_i.var_idx;
        ih_ra     = cmd_i.var_idx;
        ih_we     = 1'b0;
        ih_wa     = var_reg;
        ih_wd     = 1'b0;
        act_we    = 1'b0;
        act_wa    = var_reg;
        act_wd    = bump_act;

        case (state_reg)
            S_IDLE: begin
                act_ra_a = cmd_i.var_idx;
                hs_ra_b  = VAR_W'(count_reg - CNT_W'(1));
                if (cmd_valid_i) begin
                    var_next    = cmd_i.var_idx;
                    popped_next = '0;
                    pval_next   = 1'b0;
                    case (cmd_i.op)
                        OP_INIT: begin
                            init_n_next = (cfg_i.num_vars > CNT_W'(MAX_VARS)) ?
                                          CNT_W'(MAX_VARS) : cfg_i.num_vars;
                            cnt_next    = '0;
                            state_next  = S_INIT;
                        end
                        OP_INSERT: state_next = S_IN_RD;
                        OP_BUMP:   state_next = S_BUMP_RD;
                        OP_POP:    state_next = (count_reg == '0) ? S_DONE : S_POP_TOP;
                        OP_DECAY:  state_next = S_DEC_MUL;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                // One entry of every store per cycle; the heap holds 0..n-1 in order.
                ih_we  = 1'b1;
                ih_wa  = cnt_reg[VAR_W-1:0];
                ih_wd  = cnt_reg < init_n_reg;
                act_we = 1'b1;
                act_wa = cnt_reg[VAR_W-1:0];
                act_wd = '0;
                if (cnt_reg[VAR_W-1:0] == VAR_W'(MAX_VARS - 1)) begin
                    count_next  = init_n_reg;
                    inc_next    = ACT_ONE;
                    silent_next = 1'b0;
                    state_next  = silent_reg ? S_IDLE : S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IN_RD: begin
                if (!ih_rd_reg && (count_reg != CNT_W'(MAX_VARS))) begin
                    ih_we      = 1'b1;
                    ih_wd      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    key_next   = act_a_reg;
                    pos_next   = count_reg[VAR_W-1:0];
                    state_next = S_UP_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BUMP_RD: begin
                act_we   = 1'b1;
                pos_next = sv_rd_reg;
                inh_next = ih_rd_reg;
                if (bump_act > cfg_i.limit) begin
                    inc_next   = inc_reg >> cfg_i.shift;
                    key_next   = bump_act >> cfg_i.shift;
                    cnt_next   = '0;
                    state_next = S_RESCALE;
                end else begin
                    key_next   = bump_act;
                    state_next = ih_rd_reg ? S_UP_CHK : S_DONE;
                end
            end
            S_RESCALE: begin
                // Read entry cnt while entry cnt-1 is written back shifted.
                act_ra_a = cnt_reg[VAR_W-1:0];
                act_wa   = VAR_W'(cnt_reg - CNT_W'(1));
                act_wd   = act_a_reg >> cfg_i.shift;
                act_we   = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(MAX_VARS)) begin
                    state_next = inh_reg ? S_UP_CHK : S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_POP_TOP: begin
                act_ra_a    = hs_b_reg;
                ih_we       = 1'b1;
                ih_wa       = hs_a_reg;
                ih_wd       = 1'b0;
                popped_next = hs_a_reg;
                pval_next   = 1'b1;
                count_next  = count_reg - CNT_W'(1);
                if (count_reg > CNT_W'(1)) begin
                    var_next   = hs_b_reg;
                    pos_next   = '0;
                    state_next = S_POP_KEY;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_POP_KEY: begin
                key_next   = act_a_reg;
                state_next = S_DN_CHK;
            end
            S_UP_CHK: begin
                hs_ra_a = up_pos;
                if (pos_reg == '0) begin
                    place_en   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_SLOT;
                end
            end
            S_UP_SLOT: begin
                act_ra_a   = hs_a_reg;
                uv_next    = hs_a_reg;
                state_next = S_UP_ACT;
            end
            S_UP_ACT: begin
                place_en = 1'b1;
                if (act_a_reg >= key_reg) begin
                    state_next = S_DONE;
                end else begin
                    place_var  = uv_reg;
                    pos_next   = up_pos;
                    state_next = S_UP_CHK;
                end
            end
            S_DN_CHK: begin
                hs_ra_a = kid[VAR_W-1:0];
                hs_ra_b = kid1[VAR_W-1:0];
                if (kid >= count_reg) begin
                    place_en   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_SLOT;
                end
            end
            S_DN_SLOT: begin
                act_ra_a   = hs_a_reg;
                act_ra_b   = hs_b_reg;
                kv0_next   = hs_a_reg;
                kv1_next   = hs_b_reg;
                state_next = S_DN_ACT;
            end
            S_DN_ACT: begin
                place_en = 1'b1;
                if (kid_act <= key_reg) begin
                    state_next = S_DONE;
                end else begin
                    place_var  = take_right ? kv1_reg : kv0_reg;
                    pos_next   = take_right ? kid1[VAR_W-1:0] : kid[VAR_W-1:0];
                    state_next = S_DN_CHK;
                end
            end
            S_DEC_MUL: begin
                prod_next  = PROD_W'(inc_reg) * PROD_W'(cfg_i.factor);
                state_next = S_DEC_SAT;
            end
            S_DEC_SAT: begin
                if (dec_sum[PROD_W:16+ACT_W] != '0) begin
                    inc_next = {ACT_W{1'b1}};
                end else begin
                    inc_next = dec_sum[16+ACT_W-1:16];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_var_next   = popped_reg;
                    out_pval_next  = pval_reg;
                    out_size_next  = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        hs_we = place_en || (state_reg == S_INIT);
        hs_wa = (state_reg == S_INIT) ? cnt_reg[VAR_W-1:0] : place_pos;
        hs_wd = (state_reg == S_INIT) ? cnt_reg[VAR_W-1:0] : place_var;
        sv_we = hs_we;
        sv_wa = hs_wd;
        sv_wd = hs_wa;
    end

    always_ff @(posedge aclk) begin
        if (hs_we) begin
            hs_mem[hs_wa] <= hs_wd;
        end
        hs_a_reg <= hs_mem[hs_ra_a];
        hs_b_reg <= hs_mem[hs_ra_b];
    end

    always_ff @(posedge aclk) begin
        if (sv_we) begin
            sv_mem[sv_wa] <= sv_wd;
        end
        sv_rd_reg <= sv_mem[sv_ra];
    end

    always_ff @(posedge aclk) begin
        if (ih_we) begin
            ih_mem[ih_wa] <= ih_wd;
        end
        ih_rd_reg <= ih_mem[ih_ra];
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[act_wa] <= act_wd;
        end
        act_a_reg <= act_mem[act_ra_a];
        act_b_reg <= act_mem[act_ra_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset runs the init sweep with an empty heap and no result.
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            init_n_reg    <= '0;
            silent_reg    <= 1'b1;
            count_reg     <= '0;
            inc_reg       <= ACT_ONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_n_reg    <= init_n_next;
            silent_reg    <= silent_next;
            count_reg     <= count_next;
            inc_reg       <= inc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        var_reg      <= var_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        inh_reg      <= inh_next;
        uv_reg       <= uv_next;
        kv0_reg      <= kv0_next;
        kv1_reg      <= kv1_next;
        prod_reg     <= prod_next;
        popped_reg   <= popped_next;
        pval_reg     <= pval_next;
        out_var_reg  <= out_var_next;
        out_pval_reg <= out_pval_next;
        out_size_reg <= out_size_next;
    end

    assign cmd_ready_o     = (state_reg == S_IDLE);
    assign m_valid         = out_valid_reg;
    assign m_popped_var    = out_var_reg;
    assign m_popped_valid  = out_pval_reg;
    assign m_heap_size     = out_size_reg;
    assign stat_o.sweeping = (state_reg == S_INIT) || (state_reg == S_RESCALE);
    assign stat_o.busy     = (state_reg != S_IDLE);

endmodule

@@ src/activity_indexed_max_heap.sv @@
// Top level of the activity heap: configuration registers, front end and back end.
// Depends on aimh_pkg, aimh_front, aimh_back and the assertion macro header.
//
// channel | direction | handshake        | payload
// s_      | in        | s_valid/s_ready  | s_req_type, s_var_index
// m_      | out       | m_valid/m_ready  | m_popped_var, m_popped_valid, m_heap_size
// apb     | in        | psel/penable     | paddr, pwdata, prdata
//
// Insert and bump climb the heap and pop descends it; each heap level takes a slot read,
// an activity read and a compare-and-write of the sift sequencer. Decay is a multiply
// step and then a saturate step; init sweeps every entry of the stores.
// A bump that passes the rescale limit adds a sweep over the activity memory.
// After reset a clearing pass runs before the back end takes the first command.
// Up to two beats queue at the input while the back end works or the result waits.
`include "activity_indexed_max_heap_macros.svh"

module activity_indexed_max_heap (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aimh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [aimh_pkg::REQ_W-1:0]  s_req_type,
    input  logic [aimh_pkg::VAR_W-1:0]  s_var_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [aimh_pkg::VAR_W-1:0]  m_popped_var,
    output logic                        m_popped_valid,
    output logic [aimh_pkg::CNT_W-1:0]  m_heap_size
);
    import aimh_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd;
    logic  cmd_valid, cmd_ready;
    stat_t stat;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_NUM_VARS: cfg_next.num_vars = pwdata[CNT_W-1:0];
                REG_FACTOR:   cfg_next.factor   = pwdata[FAC_W-1:0];
                REG_LIMIT:    cfg_next.limit    = pwdata[ACT_W-1:0];
                REG_SHIFT:    cfg_next.shift    = pwdata[SHF_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM_VARS: prdata = 32'(cfg_reg.num_vars);
            REG_FACTOR:   prdata = 32'(cfg_reg.factor);
            REG_LIMIT:    prdata = 32'(cfg_reg.limit);
            REG_SHIFT:    prdata = 32'(cfg_reg.shift);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_vars <= '0;
            cfg_reg.factor   <= FAC_W'(68985);
            cfg_reg.limit    <= ACT_W'(32'h8000_0000);
            cfg_reg.shift    <= SHF_W'(16);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    aimh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_var_index (s_var_index),
        .cmd_o       (cmd),
        .cmd_valid_o (cmd_valid),
        .cmd_ready_i (cmd_ready)
    );

    aimh_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_i          (cfg_reg),
        .cmd_i          (cmd),
        .cmd_valid_i    (cmd_valid),
        .cmd_ready_o    (cmd_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_var   (m_popped_var),
        .m_popped_valid (m_popped_valid),
        .m_heap_size    (m_heap_size),
        .stat_o         (stat)
    );

    // A successful pop always leaves room for at least one more variable.
    `AIMH_ASSERT_SAME(a_pop_size, m_valid && m_popped_valid, m_heap_size < CNT_W'(MAX_VARS), "pop reported a full heap")
    `AIMH_ASSERT_SAME(a_size_max, m_valid, m_heap_size <= CNT_W'(MAX_VARS), "heap size beyond capacity")
    // No command may leave the queue while a sweep owns the memories.
    `AIMH_ASSERT_SAME(a_sweep_hold, stat.sweeping, !cmd_ready, "command taken during a sweep")
    `AIMH_ASSERT_NEXT(a_take_busy, cmd_valid && cmd_ready, stat.busy, "back end idle after taking a command")

endmodule
